// ----- rtl/core/cltsc_pkg.sv -----
// Package for the command line token syntax checker.
// Token event type, verdict and grammar state codes, character constants.
// No dependencies.
`default_nettype none
package cltsc_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [1:0] MIN_OPT_LEN = 2'd2;

    localparam logic [1:0] TK_NAME = 2'd0;
    localparam logic [1:0] TK_OPT  = 2'd1;
    localparam logic [1:0] TK_ARG  = 2'd2;

    localparam logic [2:0] GS_START = 3'd0;
    localparam logic [2:0] GS_NAME  = 3'd1;
    localparam logic [2:0] GS_OPT   = 3'd2;
    localparam logic [2:0] GS_ARG   = 3'd3;
    localparam logic [2:0] GS_END   = 3'd4;
    localparam logic [2:0] GS_DEAD  = 3'd7;

    localparam logic [2:0] VD_COMPLETE  = 3'd0;
    localparam logic [2:0] VD_EARLY_END = 3'd1;
    localparam logic [2:0] VD_LEX_ERR   = 3'd2;
    localparam logic [2:0] VD_SYN_ERR   = 3'd3;
    localparam logic [2:0] VD_FIRST_BAD = 3'd4;

    typedef struct packed {
        logic       has_token;
        logic [1:0] kind;
        logic       lex_err;
        logic       eol;
    } t_tok_evt;

endpackage
`default_nettype wire

// ----- rtl/core/cltsc_if.sv -----
// Valid/ready channel interfaces for the syntax checker.
// Depends on nothing; payload widths are fixed by the item fields.
`default_nettype none
interface cltsc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;
    modport source (output valid, char_code, line_end, input ready);
    modport sink   (input valid, char_code, line_end, output ready);
endinterface

interface cltsc_verdict_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [2:0] grammar_state;
    modport source (output valid, verdict, grammar_state, input ready);
    modport sink   (input valid, verdict, grammar_state, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cltsc_lexer.sv -----
// Front end: splits the character stream into tokens and classifies them.
// Emits one token event per finished token or end of line. Uses cltsc_pkg.
`default_nettype none
module cltsc_lexer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [7:0]          i_char_code,
    input  wire logic                i_line_end,
    output logic                     o_ready,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output cltsc_pkg::t_tok_evt      o_evt
);

    localparam logic [1:0] LM_BETWEEN = 2'd0;
    localparam logic [1:0] LM_PLAIN   = 2'd1;
    localparam logic [1:0] LM_QUOTE   = 2'd2;

    logic [1:0] r_mode, n_mode;
    logic [1:0] r_len, n_len;
    logic       r_dash, n_dash;
    logic       r_alpha, n_alpha;
    logic       acc, is_ws, is_letter;
    logic [1:0] len_inc;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign is_ws   = (i_char_code == 8'd32) || (i_char_code inside {[8'd9:8'd13]});
    assign is_letter = (i_char_code inside {[8'd65:8'd90], [8'd97:8'd122]});
    assign len_inc = (r_len < 2'd2) ? r_len + 2'd1 : r_len;

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_dash  = r_dash;
        n_alpha = r_alpha;
        o_evt   = '0;
        if (i_line_end) begin
            o_evt.eol = 1'b1;
            case (r_mode)
                LM_PLAIN: begin
                    o_evt.has_token = 1'b1;
                    o_evt.kind      = r_dash ? cltsc_pkg::TK_OPT : cltsc_pkg::TK_NAME;
                    o_evt.lex_err   = r_dash ? (r_len < cltsc_pkg::MIN_OPT_LEN) : !r_alpha;
                end
                LM_QUOTE: begin
                    o_evt.has_token = 1'b1;
                    o_evt.kind      = (r_len == 2'd1) ? cltsc_pkg::TK_ARG : cltsc_pkg::TK_NAME;
                    o_evt.lex_err   = (r_len != 2'd1);
                end
                default: ;
            endcase
            n_mode  = LM_BETWEEN;
            n_len   = 2'd0;
            n_dash  = 1'b0;
            n_alpha = 1'b1;
        end else begin
            case (r_mode)
                LM_PLAIN: begin
                    if (is_ws) begin
                        o_evt.has_token = 1'b1;
                        o_evt.kind      = r_dash ? cltsc_pkg::TK_OPT : cltsc_pkg::TK_NAME;
                        o_evt.lex_err   = r_dash ? (r_len < cltsc_pkg::MIN_OPT_LEN)
                                                 : !r_alpha;
                        n_mode = LM_BETWEEN;
                    end else begin
                        n_len   = len_inc;
                        n_alpha = r_alpha && is_letter;
                    end
                end
                LM_QUOTE: begin
                    if (i_char_code == cltsc_pkg::CH_QUOTE) begin
                        o_evt.has_token = 1'b1;
                        o_evt.kind      = cltsc_pkg::TK_ARG;
                        n_mode = LM_BETWEEN;
                    end else begin
                        n_len = len_inc;
                    end
                end
                default: begin
                    if (!is_ws) begin
                        n_len = 2'd1;
                        if (i_char_code == cltsc_pkg::CH_QUOTE) begin
                            n_mode  = LM_QUOTE;
                            n_dash  = 1'b0;
                            n_alpha = 1'b0;
                        end else begin
                            n_mode  = LM_PLAIN;
                            n_dash  = (i_char_code == cltsc_pkg::CH_DASH);
                            n_alpha = is_letter;
                        end
                    end
                end
            endcase
        end
    end

    assign o_push = acc && (o_evt.eol || o_evt.has_token);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LM_BETWEEN;
            r_len   <= 2'd0;
            r_dash  <= 1'b0;
            r_alpha <= 1'b1;
        end else if (acc) begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_dash  <= n_dash;
            r_alpha <= n_alpha;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/cltsc_queue.sv -----
// Short FIFO of token events between the lexer and the grammar checker.
// Depth from cltsc_pkg::QDEPTH. Uses cltsc_pkg.
`default_nettype none
module cltsc_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire cltsc_pkg::t_tok_evt i_evt,
    output logic                     o_full,
    input  wire logic                i_pop,
    output cltsc_pkg::t_tok_evt      o_evt,
    output logic                     o_empty
);

    cltsc_pkg::t_tok_evt r_mem [cltsc_pkg::QDEPTH];
    logic [cltsc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [cltsc_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == cltsc_pkg::QCNT_W'(cltsc_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + cltsc_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - cltsc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + cltsc_pkg::QPTR_W'(1);
            if (do_pop)  r_rd <= r_rd + cltsc_pkg::QPTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/cltsc_grammar.sv -----
// Back end: runs the token grammar, decides one verdict per line and
// holds it in the output register. Uses cltsc_pkg.
`default_nettype none
module cltsc_grammar (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cltsc_pkg::t_tok_evt i_evt,
    input  wire logic                i_empty,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [2:0]               o_verdict,
    output logic [2:0]               o_grammar_state
);

    logic [2:0] r_state, n_state;
    logic       r_decided, n_decided;
    logic       r_ovalid;
    logic [2:0] r_verdict, r_gstate;
    logic       emit;
    logic [2:0] e_verdict, e_gstate, ns;

    function automatic logic [2:0] next_state(input logic [2:0] s, input logic [1:0] k);
        case (s)
            cltsc_pkg::GS_START: next_state = (k == cltsc_pkg::TK_NAME) ? cltsc_pkg::GS_NAME
                                                                        : cltsc_pkg::GS_DEAD;
            cltsc_pkg::GS_NAME:  next_state = (k == cltsc_pkg::TK_OPT) ? cltsc_pkg::GS_OPT :
                                              (k == cltsc_pkg::TK_ARG) ? cltsc_pkg::GS_END :
                                                                         cltsc_pkg::GS_DEAD;
            cltsc_pkg::GS_OPT:   next_state = (k == cltsc_pkg::TK_OPT) ? cltsc_pkg::GS_OPT :
                                              (k == cltsc_pkg::TK_ARG) ? cltsc_pkg::GS_ARG :
                                                                         cltsc_pkg::GS_DEAD;
            cltsc_pkg::GS_ARG:   next_state = (k == cltsc_pkg::TK_OPT) ? cltsc_pkg::GS_OPT :
                                              (k == cltsc_pkg::TK_ARG) ? cltsc_pkg::GS_ARG :
                                                                         cltsc_pkg::GS_END;
            default:             next_state = cltsc_pkg::GS_DEAD;
        endcase
    endfunction

    assign o_pop = !i_empty && (!r_ovalid || i_ready);
    assign ns    = next_state(r_state, i_evt.kind);

    always_comb begin
        n_state   = r_state;
        n_decided = r_decided;
        emit      = 1'b0;
        e_verdict = cltsc_pkg::VD_COMPLETE;
        e_gstate  = r_state;
        if (!r_decided && i_evt.has_token) begin
            if (i_evt.lex_err) begin
                emit      = 1'b1;
                e_verdict = cltsc_pkg::VD_LEX_ERR;
            end else if (r_state == cltsc_pkg::GS_START) begin
                if (i_evt.kind != cltsc_pkg::TK_NAME) begin
                    emit      = 1'b1;
                    e_verdict = cltsc_pkg::VD_FIRST_BAD;
                end else begin
                    n_state = cltsc_pkg::GS_NAME;
                end
            end else if (ns == cltsc_pkg::GS_DEAD) begin
                emit      = 1'b1;
                e_verdict = cltsc_pkg::VD_SYN_ERR;
            end else begin
                n_state = ns;
                if (ns == cltsc_pkg::GS_END) begin
                    emit      = 1'b1;
                    e_verdict = cltsc_pkg::VD_COMPLETE;
                    e_gstate  = cltsc_pkg::GS_END;
                end
            end
        end
        if (emit) n_decided = 1'b1;
        if (i_evt.eol) begin
            if (!r_decided && !emit) begin
                emit      = 1'b1;
                e_gstate  = n_state;
                e_verdict = (n_state == cltsc_pkg::GS_START) ? cltsc_pkg::VD_FIRST_BAD
                                                             : cltsc_pkg::VD_EARLY_END;
            end
            n_state   = cltsc_pkg::GS_START;
            n_decided = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cltsc_pkg::GS_START;
            r_decided <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state   <= n_state;
                r_decided <= n_decided;
            end
            if (o_pop && emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_verdict <= e_verdict;
            r_gstate  <= e_gstate;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_verdict       = r_verdict;
    assign o_grammar_state = r_gstate;

endmodule
`default_nettype wire

// ----- rtl/core/command_line_token_syntax_checker_unit.sv -----
// Top level of the command line token syntax checker: lexer, event queue,
// grammar checker. Uses cltsc_pkg, cltsc_if, cltsc_lexer, cltsc_queue, cltsc_grammar.
//
//   channel     dir   payload                         request
//   i_char      in    char_code[7:0], line_end        one character or end of line
//   o_verdict   out   verdict[2:0], grammar_state[2:0] one verdict per line
//
// One request per cycle is taken while the event queue is not full. A verdict
// follows the request that decides it through the lexer-to-queue write, then the
// grammar stage to the output register. Reset clears lexer, queue and grammar state.
// A stalled output holds the grammar stage; the lexer keeps taking requests
// until the four-entry event queue fills.
`default_nettype none
module command_line_token_syntax_checker_unit (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cltsc_char_if.sink     i_char,
    cltsc_verdict_if.source o_verdict
);

    cltsc_pkg::t_tok_evt lx_evt, q_evt;
    logic lx_push, q_full, q_pop, q_empty;

    cltsc_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_char.valid),
        .i_char_code (i_char.char_code),
        .i_line_end  (i_char.line_end),
        .o_ready     (i_char.ready),
        .i_q_full    (q_full),
        .o_push      (lx_push),
        .o_evt       (lx_evt)
    );

    cltsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lx_push),
        .i_evt   (lx_evt),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_evt   (q_evt),
        .o_empty (q_empty)
    );

    cltsc_grammar u_grammar (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_evt           (q_evt),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_valid         (o_verdict.valid),
        .i_ready         (o_verdict.ready),
        .o_verdict       (o_verdict.verdict),
        .o_grammar_state (o_verdict.grammar_state)
    );

endmodule
`default_nettype wire

// ----- rtl/core/cltsc_checker.sv -----
// Port-level checks for the syntax checker top level, with its bind.
// Depends on cltsc_pkg codes and the top level's channel interfaces.
`default_nettype none
module cltsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [2:0] i_verdict,
    input wire logic [2:0] i_gstate
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_verdict) && $stable(i_gstate))
        else $error("verdict dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("verdict valid right after reset");

    a_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_verdict == cltsc_pkg::VD_COMPLETE |-> i_gstate == cltsc_pkg::GS_END)
        else $error("complete verdict outside end state");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_verdict == cltsc_pkg::VD_FIRST_BAD |-> i_gstate == cltsc_pkg::GS_START)
        else $error("first-token verdict outside start state");

    a_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_verdict == cltsc_pkg::VD_EARLY_END |->
            (i_gstate == cltsc_pkg::GS_NAME || i_gstate == cltsc_pkg::GS_OPT ||
             i_gstate == cltsc_pkg::GS_ARG))
        else $error("early end verdict in wrong state");

endmodule

bind command_line_token_syntax_checker_unit cltsc_checker u_cltsc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_verdict.valid),
    .i_ready   (o_verdict.ready),
    .i_verdict (o_verdict.verdict),
    .i_gstate  (o_verdict.grammar_state)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for command_line_token_syntax_checker_unit: directed command lines checked
// against listed verdicts, then random lines checked against an in-bench line grammar model.
// Depends on cltsc_pkg and the cltsc_char_if / cltsc_verdict_if interfaces.
`default_nettype none
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] LX_IDLE  = 2'd0;
    localparam logic [1:0] LX_PLAIN = 2'd1;
    localparam logic [1:0] LX_QUOTE = 2'd2;
    localparam int         HOLD_CYCLES = 80;
    localparam int         LIVE_TARGET = 900;

    typedef struct packed {
        logic [2:0] vd;
        logic [2:0] gs;
    } t_line_verdict;

    typedef struct {
        string      text;
        logic [7:0] eol_code;
        logic [2:0] vd;
        logic [2:0] gs;
    } t_probe_line;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cltsc_char_if    char_bus();
    cltsc_verdict_if verdict_bus();

    command_line_token_syntax_checker_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (char_bus),
        .o_verdict (verdict_bus)
    );

    always #1 i_clk = ~i_clk;

    // line checker model state
    logic [1:0] lx_mode;
    logic [1:0] tok_len;
    logic       tok_dash;
    logic       tok_alpha;
    logic [2:0] gram_st;
    logic       line_done;

    t_line_verdict pending_verdicts[$];
    logic [7:0]    line_buf[$];
    t_probe_line   probes[8];

    int         errors = 0;
    int         live_items = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    bit         row_typed = 1'b0;
    logic [2:0] typed_vd = '0;
    logic [2:0] typed_gs = '0;

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic void line_clear();
        lx_mode   = LX_IDLE;
        tok_len   = 2'd0;
        tok_dash  = 1'b0;
        tok_alpha = 1'b1;
        gram_st   = cltsc_pkg::GS_START;
        line_done = 1'b0;
    endfunction

    function automatic bit grade_token(input logic [1:0] kind, input bit bad,
                                       output logic [2:0] vd, output logic [2:0] gs);
        logic [2:0] nxt;
        vd = cltsc_pkg::VD_COMPLETE;
        gs = cltsc_pkg::GS_START;
        if (line_done) return 1'b0;
        if (bad) begin
            vd = cltsc_pkg::VD_LEX_ERR;
            gs = gram_st;
            line_done = 1'b1;
            return 1'b1;
        end
        if (gram_st == cltsc_pkg::GS_START) begin
            if (kind != cltsc_pkg::TK_NAME) begin
                vd = cltsc_pkg::VD_FIRST_BAD;
                line_done = 1'b1;
                return 1'b1;
            end
            gram_st = cltsc_pkg::GS_NAME;
            return 1'b0;
        end
        case (gram_st)
            cltsc_pkg::GS_NAME: begin
                nxt = (kind == cltsc_pkg::TK_OPT) ? cltsc_pkg::GS_OPT :
                      (kind == cltsc_pkg::TK_ARG) ? cltsc_pkg::GS_END : cltsc_pkg::GS_DEAD;
            end
            cltsc_pkg::GS_OPT: begin
                nxt = (kind == cltsc_pkg::TK_OPT) ? cltsc_pkg::GS_OPT :
                      (kind == cltsc_pkg::TK_ARG) ? cltsc_pkg::GS_ARG : cltsc_pkg::GS_DEAD;
            end
            cltsc_pkg::GS_ARG: begin
                nxt = (kind == cltsc_pkg::TK_OPT) ? cltsc_pkg::GS_OPT :
                      (kind == cltsc_pkg::TK_ARG) ? cltsc_pkg::GS_ARG : cltsc_pkg::GS_END;
            end
            default: nxt = cltsc_pkg::GS_DEAD;
        endcase
        if (nxt == cltsc_pkg::GS_DEAD) begin
            vd = cltsc_pkg::VD_SYN_ERR;
            gs = gram_st;
            line_done = 1'b1;
            return 1'b1;
        end
        gram_st = nxt;
        if (nxt == cltsc_pkg::GS_END) begin
            vd = cltsc_pkg::VD_COMPLETE;
            gs = cltsc_pkg::GS_END;
            line_done = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit close_plain(output logic [2:0] vd, output logic [2:0] gs);
        lx_mode = LX_IDLE;
        if (tok_dash)
            return grade_token(cltsc_pkg::TK_OPT, tok_len < cltsc_pkg::MIN_OPT_LEN, vd, gs);
        return grade_token(cltsc_pkg::TK_NAME, !tok_alpha, vd, gs);
    endfunction

    function automatic bit predict_verdict(input logic [7:0] c, input logic eol,
                                           output logic [2:0] vd, output logic [2:0] gs);
        bit got;
        got = 1'b0;
        vd = cltsc_pkg::VD_COMPLETE;
        gs = cltsc_pkg::GS_START;
        if (eol) begin
            if (!line_done) begin
                if (lx_mode == LX_PLAIN)
                    got = close_plain(vd, gs);
                else if (lx_mode == LX_QUOTE && tok_len == 2'd1)
                    got = grade_token(cltsc_pkg::TK_ARG, 1'b0, vd, gs);
                else if (lx_mode == LX_QUOTE)
                    got = grade_token(cltsc_pkg::TK_NAME, 1'b1, vd, gs);
                if (!got && !line_done) begin
                    vd = (gram_st == cltsc_pkg::GS_START) ? cltsc_pkg::VD_FIRST_BAD
                                                          : cltsc_pkg::VD_EARLY_END;
                    gs = gram_st;
                    got = 1'b1;
                end
            end
            line_clear();
            return got;
        end
        if (line_done) return 1'b0;
        if (lx_mode == LX_PLAIN) begin
            if (is_space(c)) return close_plain(vd, gs);
            if (tok_len < 2'd2) tok_len++;
            if (!is_alpha(c)) tok_alpha = 1'b0;
            return 1'b0;
        end
        if (lx_mode == LX_QUOTE) begin
            if (c == cltsc_pkg::CH_QUOTE) begin
                lx_mode = LX_IDLE;
                return grade_token(cltsc_pkg::TK_ARG, 1'b0, vd, gs);
            end
            if (tok_len < 2'd2) tok_len++;
            return 1'b0;
        end
        if (is_space(c)) return 1'b0;
        tok_len = 2'd1;
        if (c == cltsc_pkg::CH_QUOTE) begin
            lx_mode   = LX_QUOTE;
            tok_dash  = 1'b0;
            tok_alpha = 1'b0;
        end else begin
            lx_mode   = LX_PLAIN;
            tok_dash  = (c == cltsc_pkg::CH_DASH);
            tok_alpha = is_alpha(c);
        end
        return 1'b0;
    endfunction

    // request side: model update on every accepted request
    always @(posedge i_clk) begin
        logic [2:0] p_vd;
        logic [2:0] p_gs;
        if (i_rst_n && char_bus.valid && char_bus.ready) begin
            live_items++;
            if (predict_verdict(char_bus.char_code, char_bus.line_end, p_vd, p_gs)) begin
                if (row_typed) pending_verdicts.push_back(t_line_verdict'{typed_vd, typed_gs});
                else pending_verdicts.push_back(t_line_verdict'{p_vd, p_gs});
            end
        end
    end

    // verdict side
    always @(posedge i_clk) begin
        t_line_verdict want;
        if (i_rst_n && verdict_bus.valid && verdict_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict expected none actual %0d state %0d", $realtime,
                         verdict_bus.verdict, verdict_bus.grammar_state);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (verdict_bus.verdict !== want.vd) begin
                    $display("%0t: verdict expected %0d actual %0d", $realtime,
                             want.vd, verdict_bus.verdict);
                    errors++;
                end
                if (verdict_bus.grammar_state !== want.gs) begin
                    $display("%0t: grammar_state expected %0d actual %0d", $realtime,
                             want.gs, verdict_bus.grammar_state);
                    errors++;
                end
            end
        end
    end

    initial begin
        verdict_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                verdict_bus.ready = 1'b0;
                hold_left--;
            end else begin
                verdict_bus.ready = calm || ($urandom_range(99) >= 24);
            end
        end
    end

    task automatic send_req(input logic [7:0] code, input logic eol, input bit typed,
                            input logic [2:0] t_vd, input logic [2:0] t_gs);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 24) begin
            char_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid     = 1'b1;
        char_bus.char_code = code;
        char_bus.line_end  = eol;
        row_typed = typed;
        typed_vd  = t_vd;
        typed_gs  = t_gs;
        do @(posedge i_clk); while (!char_bus.ready);
    endtask

    function automatic logic [7:0] pick_ws();
        if ($urandom_range(5) == 0) return 8'd32;
        return 8'(9 + $urandom_range(4));
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(1) == 1) return 8'(65 + $urandom_range(25));
        return 8'(97 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_solid();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (is_space(c));
        return c;
    endfunction

    function automatic void push_gap();
        repeat ($urandom_range(1, 2)) line_buf.push_back(pick_ws());
    endfunction

    function automatic void push_name(input bit good);
        int n;
        int bad_at;
        logic [7:0] c;
        n = $urandom_range(1, 4);
        bad_at = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
            if (!good && i == bad_at) begin
                do c = pick_solid();
                while (is_alpha(c) ||
                       (i == 0 && (c == cltsc_pkg::CH_DASH || c == cltsc_pkg::CH_QUOTE)));
                line_buf.push_back(c);
            end else begin
                line_buf.push_back(pick_letter());
            end
        end
    endfunction

    function automatic void push_opt(input bit good);
        line_buf.push_back(cltsc_pkg::CH_DASH);
        if (good) repeat ($urandom_range(1, 3)) line_buf.push_back(pick_solid());
    endfunction

    function automatic void push_arg(input bit closed);
        logic [7:0] c;
        line_buf.push_back(cltsc_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 3)) begin
            do c = 8'($urandom_range(255)); while (c == cltsc_pkg::CH_QUOTE);
            line_buf.push_back(c);
        end
        if (closed) line_buf.push_back(cltsc_pkg::CH_QUOTE);
    endfunction

    // mostly well-formed command lines, some broken ones, some raw noise
    function automatic void build_line();
        int style;
        int pick;
        bit after_quote;
        line_buf.delete();
        after_quote = 1'b0;
        style = $urandom_range(99);
        if (style < 70) begin
            if ($urandom_range(3) == 0) push_gap();
            push_name(1'b1);
            repeat ($urandom_range(0, 5)) begin
                if (!after_quote || $urandom_range(1) == 1) push_gap();
                pick = $urandom_range(11);
                after_quote = 1'b0;
                if (pick < 5) begin
                    push_opt(1'b1);
                end else if (pick < 10) begin
                    push_arg(1'b1);
                    after_quote = 1'b1;
                end else if (pick == 10) begin
                    push_name(1'b1);
                end else begin
                    line_buf.push_back(cltsc_pkg::CH_QUOTE);
                end
            end
            if ($urandom_range(2) == 0) push_gap();
        end else if (style < 85) begin
            repeat ($urandom_range(1, 4)) begin
                if (!after_quote || $urandom_range(1) == 1) push_gap();
                pick = $urandom_range(5);
                after_quote = (pick == 4);
                case (pick)
                    0, 1:    push_name(pick == 0);
                    2, 3:    push_opt(pick == 2);
                    default: push_arg(pick == 4);
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(255)));
        end
    endfunction

    initial begin
        int line_no;
        char_bus.valid     = 1'b0;
        char_bus.char_code = 8'd0;
        char_bus.line_end  = 1'b0;
        line_clear();
        probes = '{
            '{"",        8'hFF, cltsc_pkg::VD_FIRST_BAD, cltsc_pkg::GS_START},
            '{"a \"b\"", 8'h00, cltsc_pkg::VD_COMPLETE,  cltsc_pkg::GS_END},
            '{"-",       8'h00, cltsc_pkg::VD_LEX_ERR,   cltsc_pkg::GS_START},
            '{"\"",      8'h00, cltsc_pkg::VD_FIRST_BAD, cltsc_pkg::GS_START},
            '{"a -x",    8'h00, cltsc_pkg::VD_EARLY_END, cltsc_pkg::GS_OPT},
            '{"a a",     8'h00, cltsc_pkg::VD_SYN_ERR,   cltsc_pkg::GS_NAME},
            '{"\377",    8'h00, cltsc_pkg::VD_LEX_ERR,   cltsc_pkg::GS_START},
            '{"\"ab",    8'h00, cltsc_pkg::VD_LEX_ERR,   cltsc_pkg::GS_START}
        };
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (probes[r]) begin
            for (int k = 0; k < probes[r].text.len(); k++)
                send_req(probes[r].text[k], 1'b0, 1'b1, probes[r].vd, probes[r].gs);
            send_req(probes[r].eol_code, 1'b1, 1'b1, probes[r].vd, probes[r].gs);
        end

        line_no = 0;
        while (live_items < LIVE_TARGET) begin
            calm = (line_no >= 10 && line_no < 25);
            if (line_no == 35) hold_req = 1'b1;
            if (line_no == 50) begin
                while (pending_verdicts.size() != 0) @(posedge i_clk);
                repeat (5) @(posedge i_clk);
            end
            build_line();
            foreach (line_buf[k]) send_req(line_buf[k], 1'b0, 1'b0, '0, '0);
            send_req(8'($urandom_range(255)), 1'b1, 1'b0, '0, '0);
            line_no++;
        end
        calm = 1'b0;
        @(negedge i_clk);
        char_bus.valid = 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
